// ===== rtl/jasp_pkg.sv =====
// shared types and constants for the joint action to servo pulse block
// no dependencies; imported by every module of the block

package jasp_pkg;

    // configuration port
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    // register indexes, byte address is 4 * index
    typedef enum logic [2:0] {
        REG_STEP_GAIN      = 3'd0,
        REG_SHOULDER_OFF   = 3'd1,
        REG_KNEE_OFF_FRONT = 3'd2,
        REG_KNEE_OFF_REAR  = 3'd3,
        REG_SIGN_MASK      = 3'd4,
        REG_PULSE_LOW      = 3'd5,
        REG_PULSE_HIGH     = 3'd6,
        REG_TICKS_PER_DEG  = 3'd7
    } t_reg_idx;

    // register reset values
    localparam logic [15:0]        RST_STEP_GAIN      = 16'd10923;
    localparam logic signed [15:0] RST_SHOULDER_OFF   = 16'sd1434;
    localparam logic signed [15:0] RST_KNEE_OFF_FRONT = -16'sd3215;
    localparam logic signed [15:0] RST_KNEE_OFF_REAR  = 16'sd3215;
    localparam logic [7:0]         RST_SIGN_MASK      = 8'd201;
    localparam logic [11:0]        RST_PULSE_LOW      = 12'd400;
    localparam logic [11:0]        RST_PULSE_HIGH     = 12'd1950;
    localparam logic [11:0]        RST_TICKS_PER_DEG  = 12'd2204;

    typedef struct packed {
        logic [15:0]        step_gain;
        logic signed [15:0] shoulder_offset;
        logic signed [15:0] knee_offset_front;
        logic signed [15:0] knee_offset_rear;
        logic [7:0]         sign_mask;
        logic [11:0]        pulse_low;
        logic [11:0]        pulse_high;
        logic [11:0]        ticks_per_degree;
    } t_cfg;

    // fixed point constants
    localparam logic signed [24:0] PI_Q20          = 25'sd3294199;
    localparam logic [21:0]        DEG_PER_RAD_Q16 = 22'd3754936;
    localparam logic [13:0]        LIMIT_Q7        = 14'd11520;
    localparam logic signed [13:0] ACT_MAX         = 14'sd4096;

    // serial multiplier: signed multiplicand times unsigned multiplier
    localparam int MUL_A_W   = 26;
    localparam int MUL_B_W   = 22;
    localparam int MUL_P_W   = MUL_A_W + 1 + MUL_B_W;
    localparam int MUL_CNT_W = $clog2(MUL_B_W + 1);

    typedef struct packed {
        logic                      start;
        logic signed [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0]        b;
    } t_mul_req;

    typedef struct packed {
        logic                      done;
        logic signed [MUL_P_W-1:0] product;
    } t_mul_rsp;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1,
        ST_STEP,
        ST_CLAMP,
        ST_MUL2,
        ST_DEG,
        ST_MAG,
        ST_MUL3,
        ST_PULSE,
        ST_OUT
    } t_state;

    // target reset value of a joint, its reset offset in Q3.20
    function automatic logic signed [23:0] reset_target(input int j);
        logic signed [15:0] off;
        if ((j & 7) < 4) begin
            off = RST_SHOULDER_OFF;
        end else if ((j & 1) != 0) begin
            off = RST_KNEE_OFF_REAR;
        end else begin
            off = RST_KNEE_OFF_FRONT;
        end
        return {off, 8'b0};
    endfunction

endpackage

// ===== rtl/jasp_cfg.sv =====
// configuration register file behind an apb-style write/read port
// depends on jasp_pkg for the register map and reset values

module jasp_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [jasp_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [jasp_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [jasp_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready,
    output jasp_pkg::t_cfg                  o_cfg
);
    import jasp_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[CFG_ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign o_cfg   = r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_gain         <= RST_STEP_GAIN;
            r_cfg.shoulder_offset   <= RST_SHOULDER_OFF;
            r_cfg.knee_offset_front <= RST_KNEE_OFF_FRONT;
            r_cfg.knee_offset_rear  <= RST_KNEE_OFF_REAR;
            r_cfg.sign_mask         <= RST_SIGN_MASK;
            r_cfg.pulse_low         <= RST_PULSE_LOW;
            r_cfg.pulse_high        <= RST_PULSE_HIGH;
            r_cfg.ticks_per_degree  <= RST_TICKS_PER_DEG;
        end else if (wr_en) begin
            case (reg_idx)
                REG_STEP_GAIN:      r_cfg.step_gain         <= pwdata[15:0];
                REG_SHOULDER_OFF:   r_cfg.shoulder_offset   <= $signed(pwdata[15:0]);
                REG_KNEE_OFF_FRONT: r_cfg.knee_offset_front <= $signed(pwdata[15:0]);
                REG_KNEE_OFF_REAR:  r_cfg.knee_offset_rear  <= $signed(pwdata[15:0]);
                REG_SIGN_MASK:      r_cfg.sign_mask         <= pwdata[7:0];
                REG_PULSE_LOW:      r_cfg.pulse_low         <= pwdata[11:0];
                REG_PULSE_HIGH:     r_cfg.pulse_high        <= pwdata[11:0];
                REG_TICKS_PER_DEG:  r_cfg.ticks_per_degree  <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    // read mux, signed registers read back sign extended
    always_comb begin
        case (reg_idx)
            REG_STEP_GAIN:      prdata = CFG_DATA_W'(r_cfg.step_gain);
            REG_SHOULDER_OFF:   prdata = CFG_DATA_W'(r_cfg.shoulder_offset);
            REG_KNEE_OFF_FRONT: prdata = CFG_DATA_W'(r_cfg.knee_offset_front);
            REG_KNEE_OFF_REAR:  prdata = CFG_DATA_W'(r_cfg.knee_offset_rear);
            REG_SIGN_MASK:      prdata = CFG_DATA_W'(r_cfg.sign_mask);
            REG_PULSE_LOW:      prdata = CFG_DATA_W'(r_cfg.pulse_low);
            REG_PULSE_HIGH:     prdata = CFG_DATA_W'(r_cfg.pulse_high);
            REG_TICKS_PER_DEG:  prdata = CFG_DATA_W'(r_cfg.ticks_per_degree);
            default:            prdata = '0;
        endcase
    end

endmodule

// ===== rtl/jasp_serial_mul.sv =====
// shift-add multiplier, one multiplier bit per cycle, signed times unsigned
// depends on jasp_pkg for operand widths and the request/response structs

module jasp_serial_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  jasp_pkg::t_mul_req i_req,
    output jasp_pkg::t_mul_rsp o_rsp
);
    import jasp_pkg::*;

    logic signed [MUL_A_W-1:0] r_a;
    logic signed [MUL_A_W:0]   r_hi;
    logic [MUL_B_W-1:0]        r_lo;
    logic [MUL_CNT_W-1:0]      r_cnt;
    logic                      r_busy;
    logic                      r_done;

    logic signed [MUL_A_W+1:0] addend;
    logic signed [MUL_A_W+1:0] sum;

    // partial product add on the upper half
    always_comb begin
        addend = r_lo[0] ? (MUL_A_W+2)'(r_a) : '0;
        sum    = (MUL_A_W+2)'(r_hi) + addend;
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= MUL_CNT_W'(MUL_B_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == MUL_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // product shift register, multiplier bits leave at the bottom
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a  <= i_req.a;
            r_hi <= '0;
            r_lo <= i_req.b;
        end else if (r_busy) begin
            r_hi <= sum[MUL_A_W+1:1];
            r_lo <= {sum[0], r_lo[MUL_B_W-1:1]};
        end
    end

    assign o_rsp.done    = r_done;
    assign o_rsp.product = {r_hi, r_lo};

endmodule

// ===== rtl/joint_action_to_servo_pulse.sv =====
// joint action to servo pulse: top level with sequencer and joint target store
// depends on jasp_pkg, jasp_cfg and jasp_serial_mul

// Each input item (joint index, Q3.12 action, restart flag) yields one result
// item: the Q8.7 angle relative to the joint offset, the PWM compare count and
// a flag for the ninety degree limit; a valid joint's item also updates the
// joint's integrated Q3.20 target. All three products (gain times action, angle
// times degrees per radian, and the remaining angle times ticks per degree) go
// through one shift-add multiplier that retires one multiplier bit per cycle.
// The input stalls from acceptance until the result enters the output register;
// an item for a joint beyond NUM_JOINTS skips the multiplier and leaves with
// zero angle and pulse. The input is taken again while a finished result still
// waits in the output register. Configuration writes go through the apb-style
// port at byte address 4 * register index and belong in idle periods only;
// offset writes reach a joint target only at its next restart.

module joint_action_to_servo_pulse #(
    parameter int NUM_JOINTS = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [jasp_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [jasp_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [jasp_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready,
    // input channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [2:0]                      i_joint_index,
    input  logic signed [15:0]              i_action,
    input  logic                            i_restart,
    // output channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [2:0]                      o_joint_id,
    output logic signed [15:0]              o_angle_deg,
    output logic [11:0]                     o_pulse_ticks,
    output logic                            o_angle_limited
);
    import jasp_pkg::*;

    localparam int IDX_W = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;

    t_cfg     cfg;
    t_mul_req mul_req;
    t_mul_rsp mul_rsp;

    t_state r_state;
    t_state n_state;

    // item staging
    logic [2:0]         r_j;
    logic               r_restart;
    logic signed [21:0] r_inc;
    logic signed [24:0] r_t;
    logic signed [17:0] r_deg;
    logic signed [15:0] r_angle;
    logic               r_limited;
    logic [11:0]        r_pulse;

    // joint targets, Q3.20
    logic signed [23:0] r_target [NUM_JOINTS];

    // output register
    logic               r_out_valid;
    logic [2:0]         r_out_id;
    logic signed [15:0] r_out_angle;
    logic [11:0]        r_out_pulse;
    logic               r_out_limited;

    // datapath signals
    logic               accept;
    logic               joint_ok;
    logic               out_load;
    logic [IDX_W-1:0]   idx;
    logic signed [13:0] act_c;
    logic signed [15:0] off;
    logic signed [23:0] off256;
    logic signed [23:0] base;
    logic signed [29:0] inc_sum;
    logic signed [23:0] t_clamp;
    logic signed [24:0] diff;
    logic signed [46:0] deg_sum;
    logic signed [18:0] deg_sgn;
    logic signed [15:0] deg_sat;
    logic signed [15:0] angle_c;
    logic [13:0]        mag;
    logic [13:0]        rem;
    logic [25:0]        p3;
    logic [12:0]        pulse_neg;
    logic signed [27:0] pulse_pos;

    jasp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    jasp_serial_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid && (r_state == ST_IDLE);
    assign joint_ok   = (32'(i_joint_index) < NUM_JOINTS);
    assign idx        = IDX_W'(r_j);

    // action clamp to plus or minus one
    always_comb begin
        if (i_action > 16'(ACT_MAX)) begin
            act_c = ACT_MAX;
        end else if (i_action < -16'(ACT_MAX)) begin
            act_c = -ACT_MAX;
        end else begin
            act_c = 14'(i_action);
        end
    end

    // joint offset: shoulders share one, knees split front and rear
    always_comb begin
        if (r_j < 3'd4) begin
            off = cfg.shoulder_offset;
        end else if (r_j[0]) begin
            off = cfg.knee_offset_rear;
        end else begin
            off = cfg.knee_offset_front;
        end
        off256 = {off, 8'b0};
        base   = r_restart ? off256 : r_target[idx];
    end

    // increment rounding, target clamp, offset removal and degree rounding
    always_comb begin
        inc_sum = mul_rsp.product[29:0] + 30'sd128;
        if (r_t > PI_Q20) begin
            t_clamp = 24'(PI_Q20);
        end else if (r_t < -PI_Q20) begin
            t_clamp = 24'(-PI_Q20);
        end else begin
            t_clamp = 24'(r_t);
        end
        diff    = 25'(t_clamp) - 25'(off256);
        deg_sum = mul_rsp.product[46:0] + 47'sd268435456;
    end

    // angle sign, saturation and distance from the ninety degree end
    always_comb begin
        deg_sgn = cfg.sign_mask[r_j] ? -19'(r_deg) : 19'(r_deg);
        if (deg_sgn > 19'sd32767) begin
            deg_sat = 16'sh7fff;
        end else if (deg_sgn < -19'sd32768) begin
            deg_sat = 16'sh8000;
        end else begin
            deg_sat = 16'(deg_sgn);
        end
        if (r_angle > $signed({2'b00, LIMIT_Q7})) begin
            angle_c = $signed({2'b00, LIMIT_Q7});
        end else if (r_angle < -$signed({2'b00, LIMIT_Q7})) begin
            angle_c = -$signed({2'b00, LIMIT_Q7});
        end else begin
            angle_c = r_angle;
        end
        mag = angle_c[15] ? 14'(-angle_c) : 14'(angle_c);
        rem = LIMIT_Q7 - mag;
    end

    // compare count from the low end or the high end
    always_comb begin
        p3        = mul_rsp.product[25:0];
        pulse_neg = 13'(cfg.pulse_low) + 13'(p3[25:15]);
        pulse_pos = $signed({1'b0, cfg.pulse_high, 15'b0}) - $signed({2'b00, p3});
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        mul_req.start = 1'b0;
        mul_req.a     = 26'(act_c);
        mul_req.b     = MUL_B_W'(cfg.step_gain);
        out_load      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (joint_ok) begin
                        mul_req.start = 1'b1;
                        n_state       = ST_MUL1;
                    end else begin
                        n_state = ST_OUT;
                    end
                end
            end
            ST_MUL1: begin
                if (mul_rsp.done) begin
                    n_state = ST_STEP;
                end
            end
            ST_STEP: begin
                n_state = ST_CLAMP;
            end
            ST_CLAMP: begin
                mul_req.start = 1'b1;
                mul_req.a     = 26'(diff);
                mul_req.b     = DEG_PER_RAD_Q16;
                n_state       = ST_MUL2;
            end
            ST_MUL2: begin
                if (mul_rsp.done) begin
                    n_state = ST_DEG;
                end
            end
            ST_DEG: begin
                n_state = ST_MAG;
            end
            ST_MAG: begin
                mul_req.start = 1'b1;
                mul_req.a     = $signed(26'(rem));
                mul_req.b     = MUL_B_W'(cfg.ticks_per_degree);
                n_state       = ST_MUL3;
            end
            ST_MUL3: begin
                if (mul_rsp.done) begin
                    n_state = ST_PULSE;
                end
            end
            ST_PULSE: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // item datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    r_j       <= i_joint_index;
                    r_restart <= i_restart;
                    r_angle   <= '0;
                    r_pulse   <= '0;
                    r_limited <= 1'b0;
                end
            end
            ST_MUL1: begin
                if (mul_rsp.done) begin
                    r_inc <= inc_sum[29:8];
                end
            end
            ST_STEP: begin
                r_t <= 25'(base) + 25'(r_inc);
            end
            ST_MUL2: begin
                if (mul_rsp.done) begin
                    r_deg <= deg_sum[46:29];
                end
            end
            ST_DEG: begin
                r_angle <= deg_sat;
            end
            ST_MAG: begin
                r_limited <= (r_angle > $signed({2'b00, LIMIT_Q7}))
                          || (r_angle < -$signed({2'b00, LIMIT_Q7}));
            end
            ST_PULSE: begin
                if (r_angle[15]) begin
                    r_pulse <= pulse_neg[12] ? 12'hfff : pulse_neg[11:0];
                end else if (pulse_pos[27]) begin
                    r_pulse <= '0;
                end else begin
                    r_pulse <= pulse_pos[26:15];
                end
            end
            default: ;
        endcase
    end

    // joint target store, written once per valid item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_JOINTS; k++) begin
                r_target[k] <= reset_target(k);
            end
        end else if (r_state == ST_CLAMP) begin
            r_target[idx] <= t_clamp;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_id      <= r_j;
            r_out_angle   <= r_angle;
            r_out_pulse   <= r_pulse;
            r_out_limited <= r_limited;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_joint_id      = r_out_id;
    assign o_angle_deg     = r_out_angle;
    assign o_pulse_ticks   = r_out_pulse;
    assign o_angle_limited = r_out_limited;

endmodule
